// File: src/odkar_pkg.sv
// ----------------------------------------------------------------------------
// odkar_pkg: shared types and constants of the open-drain key auto-repeater
// Phase, drive mode, drive request and line status codes, register indexes,
// reset values and the saturating counter helper.
// ----------------------------------------------------------------------------
package odkar_pkg;

	localparam int CNT_W    = 16;
	localparam int PERIOD_W = 14;
	localparam int SETTLE_W = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;

	// repeater phase
	typedef enum logic [1:0] {
		PH_OFF     = 2'd0,
		PH_ARMED   = 2'd1,
		PH_RUN_REL = 2'd2,
		PH_RUN_LOW = 2'd3
	} phase_t;

	// how the key line is currently driven
	typedef enum logic [2:0] {
		DM_PASSIVE_WAIT  = 3'd0,
		DM_PASSIVE       = 3'd1,
		DM_DRIVEN_LOW    = 3'd2,
		DM_RELEASED_WAIT = 3'd3,
		DM_RELEASED      = 3'd4
	} dmode_t;

	// requested drive
	typedef enum logic [1:0] {
		RQ_LOW     = 2'd0,
		RQ_RELEASE = 2'd1,
		RQ_INPUT   = 2'd2
	} dreq_t;

	// reported line status
	typedef enum logic [2:0] {
		LS_PASSIVE_LOW   = 3'd0,
		LS_PASSIVE_HIGH  = 3'd1,
		LS_DRIVEN_LOW    = 3'd2,
		LS_COLLISION     = 3'd3,
		LS_RELEASED_HIGH = 3'd4
	} lstat_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_PERIOD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_PERIOD  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_EN     = 3'd4;

	// register reset values
	localparam logic [PERIOD_W-1:0] HIGH_PERIOD_RST = 14'd500;
	localparam logic [PERIOD_W-1:0] LOW_PERIOD_RST  = 14'd100;
	localparam logic [PERIOD_W-1:0] LONG_PRESS_RST  = 14'd1000;
	localparam logic [SETTLE_W-1:0] SETTLE_RST      = 8'd3;

	// elapsed counter increment, sticks at all ones
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (&v) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
	endfunction

endpackage

// File: src/open_drain_key_auto_repeater_unit.sv
// ----------------------------------------------------------------------------
// open_drain_key_auto_repeater_unit: open-drain key auto-repeater
// One input transaction per millisecond tick. Tracks long presses of the key,
// arms and runs the release / drive-low repeat cycle, reports line status.
// ----------------------------------------------------------------------------
//
//  channel | signals                                           | direction
//  --------+---------------------------------------------------+----------
//  in      | in_valid, in_ready, line_level, stop_level        | sink
//  out     | out_valid, out_ready, drive_low, line_status,     | source
//          | long_pressed, repeat_phase                        |
//  cfg     | cfg_wr_en, cfg_index, cfg_data                    | sink
//
//  One tick per clock cycle while the output is not held: the state update is a
//  single pass of logic from the state registers into the result register, so a
//  tick is accepted every cycle unless the output is held, and its result shows in the next cycle.
//  Reset puts the repeater off, the line passive and settled, and the
//  registers at their default values.
//  in_ready drops only while a result is held and out_ready is low.
//
module open_drain_key_auto_repeater_unit
	import odkar_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  line_level,
	input  logic                  stop_level,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  drive_low,
	output logic [2:0]            line_status,
	output logic                  long_pressed,
	output logic [1:0]            repeat_phase,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	logic [PERIOD_W-1:0] high_period_q, low_period_q, long_press_q;
	logic [SETTLE_W-1:0] settle_q;
	logic                stop_en_q;

	// repeater state
	phase_t          phase_q, phase_n;
	dmode_t          dmode_q, dmode_n;
	dreq_t           dreq_q, dreq_n;
	lstat_t          last_ls_q, last_ls_n;
	logic [CNT_W-1:0] phase_el_q, phase_el_n;
	logic [CNT_W-1:0] settle_el_q, settle_el_n;
	logic [CNT_W-1:0] press_el_q, press_el_n;

	// result register
	logic   out_valid_q;
	logic   drive_low_q;
	lstat_t line_status_q;
	logic   long_q;
	phase_t phase_out_q;

	// next-state working values
	logic   settled;
	lstat_t ls_now;
	logic   is_long;
	logic   stop_req;
	logic   enter;
	phase_t enter_phase;
	dreq_t  want_req;
	dmode_t want_mode;
	lstat_t want_ls;
	logic   req_change;
	lstat_t ls_out;
	logic   accept;

	assign in_ready = ~out_valid_q | out_ready;
	assign accept   = in_valid & in_ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_period_q <= HIGH_PERIOD_RST;
			low_period_q  <= LOW_PERIOD_RST;
			long_press_q  <= LONG_PRESS_RST;
			settle_q      <= SETTLE_RST;
			stop_en_q     <= 1'b1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_HIGH_PERIOD: high_period_q <= cfg_data;
				REG_LOW_PERIOD:  low_period_q  <= cfg_data;
				REG_LONG_PRESS:  long_press_q  <= cfg_data;
				REG_SETTLE:      settle_q      <= cfg_data[SETTLE_W-1:0];
				REG_STOP_EN:     stop_en_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// one tick of the repeater
	always_comb begin
		phase_el_n  = sat_inc(phase_el_q);
		settle_el_n = sat_inc(settle_el_q);
		press_el_n  = sat_inc(press_el_q);
		dmode_n     = dmode_q;
		dreq_n      = dreq_q;
		phase_n     = phase_q;
		settled     = settle_el_n > {{(CNT_W-SETTLE_W){1'b0}}, settle_q};

		// line status, settle wait resolves here
		case (dmode_q)
			DM_PASSIVE_WAIT: begin
				if (settled) begin
					dmode_n = DM_PASSIVE;
					ls_now  = line_level ? LS_PASSIVE_HIGH : LS_PASSIVE_LOW;
				end else begin
					ls_now = LS_PASSIVE_HIGH;
				end
			end
			DM_PASSIVE:    ls_now = line_level ? LS_PASSIVE_HIGH : LS_PASSIVE_LOW;
			DM_DRIVEN_LOW: ls_now = LS_DRIVEN_LOW;
			DM_RELEASED_WAIT: begin
				if (settled) begin
					dmode_n = DM_RELEASED;
					ls_now  = line_level ? LS_RELEASED_HIGH : LS_COLLISION;
				end else begin
					ls_now = LS_RELEASED_HIGH;
				end
			end
			default: ls_now = line_level ? LS_RELEASED_HIGH : LS_COLLISION;
		endcase

		// press timer restarts on any status change
		last_ls_n = last_ls_q;
		if (ls_now != last_ls_q) begin
			last_ls_n  = ls_now;
			press_el_n = '0;
		end
		is_long = (last_ls_n == LS_PASSIVE_LOW) &&
			(press_el_n > {{(CNT_W-PERIOD_W){1'b0}}, long_press_q});

		// phase transitions
		stop_req    = stop_en_q & ~stop_level;
		enter       = 1'b0;
		enter_phase = phase_q;
		unique case (phase_q)
			PH_OFF: begin
				if (is_long) begin
					enter       = 1'b1;
					enter_phase = PH_ARMED;
				end
			end
			PH_ARMED: begin
				if (!is_long) begin
					enter       = 1'b1;
					enter_phase = PH_RUN_REL;
				end
			end
			PH_RUN_REL: begin
				if (stop_req || ls_now == LS_COLLISION) begin
					enter       = 1'b1;
					enter_phase = PH_OFF;
				end else if (phase_el_n > {{(CNT_W-PERIOD_W){1'b0}}, high_period_q}) begin
					enter       = 1'b1;
					enter_phase = PH_RUN_LOW;
				end
			end
			default: begin
				if (stop_req) begin
					enter       = 1'b1;
					enter_phase = PH_OFF;
				end else if (phase_el_n > {{(CNT_W-PERIOD_W){1'b0}}, low_period_q}) begin
					enter       = 1'b1;
					enter_phase = PH_RUN_REL;
				end
			end
		endcase

		// drive request that goes with the new phase
		case (enter_phase)
			PH_RUN_REL: begin
				want_req  = RQ_RELEASE;
				want_mode = DM_RELEASED_WAIT;
				want_ls   = LS_RELEASED_HIGH;
			end
			PH_RUN_LOW: begin
				want_req  = RQ_LOW;
				want_mode = DM_DRIVEN_LOW;
				want_ls   = LS_DRIVEN_LOW;
			end
			default: begin
				want_req  = RQ_INPUT;
				want_mode = DM_PASSIVE_WAIT;
				want_ls   = LS_PASSIVE_HIGH;
			end
		endcase

		req_change = enter && (want_req != dreq_q);
		if (enter) begin
			phase_n    = enter_phase;
			phase_el_n = '0;
		end
		if (req_change) begin
			dreq_n      = want_req;
			dmode_n     = want_mode;
			settle_el_n = '0;
		end

		// a fresh drive change is never settled yet
		ls_out = req_change ? want_ls : ls_now;
	end

	// state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_OFF;
			dmode_q     <= DM_PASSIVE;
			dreq_q      <= RQ_INPUT;
			last_ls_q   <= LS_PASSIVE_HIGH;
			phase_el_q  <= '0;
			settle_el_q <= '0;
			press_el_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q     <= phase_n;
				dmode_q     <= dmode_n;
				dreq_q      <= dreq_n;
				last_ls_q   <= last_ls_n;
				phase_el_q  <= phase_el_n;
				settle_el_q <= settle_el_n;
				press_el_q  <= press_el_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			drive_low_q   <= (dreq_n == RQ_LOW);
			line_status_q <= ls_out;
			long_q        <= is_long;
			phase_out_q   <= phase_n;
		end
	end

	assign out_valid    = out_valid_q;
	assign drive_low    = drive_low_q;
	assign line_status  = line_status_q;
	assign long_pressed = long_q;
	assign repeat_phase = phase_out_q;

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: open-drain key auto-repeater unit
// Feeds millisecond ticks of key and stop line levels through the valid/ready
// input channel and checks every result against a cycle-free model of the
// press tracker, repeat phases and line settle logic kept inside the bench.
// A short opening table covers reset values, register writes, arming,
// collisions, the stop key and settle masking. Random key press and release
// sequences follow under changing settings and back-pressure, and a final
// long hold at the longest press setting checks that nothing arms.
// ----------------------------------------------------------------------------
module testbench;
	import odkar_pkg::*;

	localparam int WATCHDOG_CYCLES = 1000;
	localparam int BLOCK_TICKS     = 80;
	localparam int SOAK_TICKS      = 40;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	// one result of one tick
	typedef struct packed {
		logic   drive_low;
		lstat_t status;
		logic   long_press;
		phase_t phase;
	} report_t;

	typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

	// opening table row: a tick repeated reps times, or one register write
	typedef struct packed {
		row_kind_t             kind;
		logic                  line;
		logic                  stop;
		logic [15:0]           reps;
		logic                  typed;
		report_t               want;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
	} stim_row_t;

	localparam int OPENING_LEN = 25;
	localparam stim_row_t OPENING_ROWS [OPENING_LEN] = '{
		'{ROW_TICK, 1'b1, 1'b1, 16'd1, 1'b1, '{1'b0, LS_PASSIVE_HIGH, 1'b0, PH_OFF}, '0, '0},
		'{ROW_TICK, 1'b0, 1'b1, 16'd1, 1'b1, '{1'b0, LS_PASSIVE_LOW, 1'b0, PH_OFF}, '0, '0},
		'{ROW_TICK, 1'b0, 1'b0, 16'd1, 1'b1, '{1'b0, LS_PASSIVE_LOW, 1'b0, PH_OFF}, '0, '0},
		'{ROW_CFG, 1'b1, 1'b1, 16'd0, 1'b0, '0, REG_LONG_PRESS, 14'd2},
		'{ROW_CFG, 1'b1, 1'b1, 16'd0, 1'b0, '0, REG_HIGH_PERIOD, 14'd3},
		'{ROW_CFG, 1'b1, 1'b1, 16'd0, 1'b0, '0, REG_LOW_PERIOD, 14'd0},
		'{ROW_CFG, 1'b1, 1'b1, 16'd0, 1'b0, '0, REG_SETTLE, 14'd0},
		'{ROW_CFG, 1'b1, 1'b1, 16'd0, 1'b0, '0, REG_STOP_EN, 14'd1},
		'{ROW_CFG, 1'b1, 1'b1, 16'd0, 1'b0, '0, REG_UNUSED, 14'h3FFF},
		// hold to arm, release to start repeating
		'{ROW_TICK, 1'b0, 1'b1, 16'd4, 1'b0, '0, '0, '0},
		'{ROW_TICK, 1'b1, 1'b1, 16'd1, 1'b0, '0, '0, '0},
		'{ROW_TICK, 1'b1, 1'b1, 16'd4, 1'b0, '0, '0, '0},
		// line pulled low from outside while released
		'{ROW_TICK, 1'b0, 1'b1, 16'd2, 1'b0, '0, '0, '0},
		// re-arm, then the stop key ends the run
		'{ROW_TICK, 1'b0, 1'b1, 16'd4, 1'b0, '0, '0, '0},
		'{ROW_TICK, 1'b1, 1'b1, 16'd2, 1'b0, '0, '0, '0},
		'{ROW_TICK, 1'b1, 1'b0, 16'd1, 1'b0, '0, '0, '0},
		// stop key disabled, upper data bits set
		'{ROW_CFG, 1'b1, 1'b1, 16'd0, 1'b0, '0, REG_STOP_EN, 14'h3FFE},
		'{ROW_TICK, 1'b0, 1'b1, 16'd4, 1'b0, '0, '0, '0},
		'{ROW_TICK, 1'b1, 1'b1, 16'd1, 1'b0, '0, '0, '0},
		'{ROW_TICK, 1'b1, 1'b0, 16'd3, 1'b0, '0, '0, '0},
		// longest settle, line low while the reading is still masked
		'{ROW_CFG, 1'b1, 1'b1, 16'd0, 1'b0, '0, REG_SETTLE, 14'h3FFF},
		'{ROW_TICK, 1'b0, 1'b0, 16'd2, 1'b0, '0, '0, '0},
		'{ROW_TICK, 1'b1, 1'b1, 16'd1, 1'b0, '0, '0, '0},
		'{ROW_TICK, 1'b0, 1'b1, 16'd1, 1'b0, '0, '0, '0},
		'{ROW_TICK, 1'b1, 1'b0, 16'd1, 1'b0, '0, '0, '0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  line_level = 1'b1;
	logic                  stop_level = 1'b1;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  drive_low;
	logic [2:0]            line_status;
	logic                  long_pressed;
	logic [1:0]            repeat_phase;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int snd_idle = 31;
	int rcv_idle = 64;
	int mismatches = 0;
	int idle_cycles = 0;
	int ticks_sent = 0;

	report_t awaited_reports [$];

	// repeater model state, reset values
	phase_t          phase_q = PH_OFF;
	dmode_t          mode_q = DM_PASSIVE;
	dreq_t           req_q = RQ_INPUT;
	lstat_t          last_status = LS_PASSIVE_HIGH;
	logic [CNT_W-1:0] phase_cnt = '0;
	logic [CNT_W-1:0] settle_cnt = '0;
	logic [CNT_W-1:0] press_cnt = '0;

	// model copy of the registers
	logic [PERIOD_W-1:0] high_r = HIGH_PERIOD_RST;
	logic [PERIOD_W-1:0] low_r = LOW_PERIOD_RST;
	logic [PERIOD_W-1:0] press_r = LONG_PRESS_RST;
	logic [SETTLE_W-1:0] settle_r = SETTLE_RST;
	logic                stop_en_r = 1'b1;

	open_drain_key_auto_repeater_unit uut (.*);

	always #5 clk = ~clk;

	// receiver back-pressure
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rcv_idle);
	end

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
		return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
	endfunction

	// line reading; leaving a settle wait once it has run out
	function automatic lstat_t line_reading(input logic ln);
		logic settled;
		settled = settle_cnt > {8'd0, settle_r};
		case (mode_q)
			DM_PASSIVE_WAIT, DM_PASSIVE: begin
				if (mode_q == DM_PASSIVE_WAIT) begin
					if (!settled) return LS_PASSIVE_HIGH;
					mode_q = DM_PASSIVE;
				end
				return ln ? LS_PASSIVE_HIGH : LS_PASSIVE_LOW;
			end
			DM_DRIVEN_LOW: return LS_DRIVEN_LOW;
			default: begin
				if (mode_q == DM_RELEASED_WAIT) begin
					if (!settled) return LS_RELEASED_HIGH;
					mode_q = DM_RELEASED;
				end
				return ln ? LS_RELEASED_HIGH : LS_COLLISION;
			end
		endcase
	endfunction

	// phase change; a new drive request restarts the settle wait
	function automatic void enter_phase(input phase_t p);
		dreq_t rq;
		phase_q = p;
		phase_cnt = '0;
		case (p)
			PH_RUN_REL: rq = RQ_RELEASE;
			PH_RUN_LOW: rq = RQ_LOW;
			default:    rq = RQ_INPUT;
		endcase
		if (rq != req_q) begin
			req_q = rq;
			settle_cnt = '0;
			case (rq)
				RQ_LOW:     mode_q = DM_DRIVEN_LOW;
				RQ_RELEASE: mode_q = DM_RELEASED_WAIT;
				default:    mode_q = DM_PASSIVE_WAIT;
			endcase
		end
	endfunction

	function automatic logic held_long();
		return last_status == LS_PASSIVE_LOW && press_cnt > {2'b00, press_r};
	endfunction

	// one millisecond tick of the repeater
	function automatic report_t advance_repeater(input logic ln, input logic st);
		report_t rep;
		lstat_t  now;
		logic    stop_req;
		phase_cnt = bump(phase_cnt);
		settle_cnt = bump(settle_cnt);
		press_cnt = bump(press_cnt);
		now = line_reading(ln);
		if (now != last_status) begin
			last_status = now;
			press_cnt = '0;
		end
		stop_req = stop_en_r && !st;
		case (phase_q)
			PH_OFF: if (held_long()) enter_phase(PH_ARMED);
			PH_ARMED: if (!held_long()) enter_phase(PH_RUN_REL);
			PH_RUN_REL: begin
				if (stop_req || line_reading(ln) == LS_COLLISION) enter_phase(PH_OFF);
				else if (phase_cnt > {2'b00, high_r}) enter_phase(PH_RUN_LOW);
			end
			default: begin
				if (stop_req) enter_phase(PH_OFF);
				else if (phase_cnt > {2'b00, low_r}) enter_phase(PH_RUN_REL);
			end
		endcase
		rep.drive_low = (req_q == RQ_LOW);
		rep.status = line_reading(ln);
		rep.long_press = held_long();
		rep.phase = phase_q;
		return rep;
	endfunction

	function automatic void check_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0d got %0d", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// result checking
	always @(posedge clk) begin : report_check
		report_t want;
		if (out_valid && out_ready) begin
			if (awaited_reports.size() == 0) begin
				$display("%0t: unexpected result drive_low %0d line_status %0d long_pressed %0d repeat_phase %0d",
					$time, drive_low, line_status, long_pressed, repeat_phase);
				mismatches++;
			end else begin
				want = awaited_reports.pop_front();
				check_field("drive_low", want.drive_low, drive_low);
				check_field("line_status", want.status, line_status);
				check_field("long_pressed", want.long_press, long_pressed);
				check_field("repeat_phase", want.phase, repeat_phase);
			end
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles > WATCHDOG_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	// one tick transaction; typed rows override the model's expectation
	task automatic send_tick(input logic ln, input logic st, input logic typed,
			input report_t want);
		report_t rep;
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		line_level <= ln;
		stop_level <= st;
		do @(posedge clk); while (!in_ready);
		rep = advance_repeater(ln, st);
		awaited_reports.push_back(typed ? want : rep);
		ticks_sent++;
	endtask

	// stop sending and let every result come back
	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (awaited_reports.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// caller lowers the write enable after the last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_HIGH_PERIOD: high_r = val;
			REG_LOW_PERIOD:  low_r = val;
			REG_LONG_PRESS:  press_r = val;
			REG_SETTLE:      settle_r = val[SETTLE_W-1:0];
			REG_STOP_EN:     stop_en_r = val[0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [CFG_DATA_W-1:0] hp, input logic [CFG_DATA_W-1:0] lp,
			input logic [CFG_DATA_W-1:0] lpress, input logic [CFG_DATA_W-1:0] st,
			input logic [CFG_DATA_W-1:0] sen);
		wait_quiet();
		write_reg(REG_HIGH_PERIOD, hp);
		write_reg(REG_LOW_PERIOD, lp);
		write_reg(REG_LONG_PRESS, lpress);
		write_reg(REG_SETTLE, st);
		write_reg(REG_STOP_EN, sen);
		write_reg(REG_UNUSED, 14'($urandom));
		cfg_wr_en <= 1'b0;
	endtask

	task automatic pick_settings(input int sel);
		case (sel)
			// longest periods and settle, press setting of one
			0: apply_settings(14'h3FFF, 14'h3FFF, 14'd1, 14'h3FFF, 14'h3FFF);
			// zero periods and no settle wait
			1: apply_settings('0, '0, '0, {6'($urandom), 8'd0}, 14'($urandom));
			// press that can never be long enough
			2: apply_settings(14'($urandom_range(1, 12)), 14'($urandom_range(1, 12)), 14'h3FFF,
				{6'($urandom), 8'($urandom_range(0, 4))}, 14'($urandom));
			default: apply_settings(14'($urandom_range(1, 12)), 14'($urandom_range(1, 12)),
				14'($urandom_range(1, 15)), {6'($urandom), 8'($urandom_range(0, 4))},
				14'($urandom));
		endcase
	endtask

	// noise, or a press, release, then a stretch of repeating with rare stops and glitches
	task automatic play_episode();
		int kind;
		int n;
		kind = $urandom_range(9);
		if (kind == 0) begin
			// noise
			n = $urandom_range(1, 16);
			repeat (n) send_tick(1'($urandom), 1'($urandom), 1'b0, '0);
		end else begin
			if (kind == 1) n = $urandom_range(1, press_r + 1);
			else n = press_r + settle_r + $urandom_range(2, 5);
			if (n > 60) n = 60;
			repeat (n) send_tick(1'b0, ($urandom_range(39) == 0) ? 1'b0 : 1'b1, 1'b0, '0);
			n = $urandom_range(1, 2 * (high_r + low_r + settle_r) + 4);
			if (n > 150) n = 150;
			// line follows our own drive unless something else pulls it low
			repeat (n) send_tick(($urandom_range(49) == 0) ? 1'b0 : (req_q != RQ_LOW),
				($urandom_range(79) == 0) ? 1'b0 : 1'b1, 1'b0, '0);
		end
	endtask

	initial begin
		int start;
		stim_row_t row;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// opening table
		for (int i = 0; i < OPENING_LEN; i++) begin
			row = OPENING_ROWS[i];
			if (row.kind == ROW_CFG) begin
				wait_quiet();
				write_reg(row.idx, row.val);
				cfg_wr_en <= 1'b0;
			end else begin
				repeat (row.reps) send_tick(row.line, row.stop, row.typed, row.want);
			end
		end

		// random sequences under three back-pressure mixes
		for (int p = 0; p < 3; p++) begin
			snd_idle = (p == 0) ? 31 : (p == 1) ? 64 : 0;
			rcv_idle = (p == 0) ? 64 : (p == 1) ? 31 : 0;
			for (int b = 0; b < 4; b++) begin
				pick_settings((b == 0) ? p : $urandom_range(2, 9));
				start = ticks_sent;
				while (ticks_sent - start < BLOCK_TICKS) play_episode();
			end
		end

		// long hold at the longest press setting, never long enough to arm
		apply_settings(14'd5, 14'd5, 14'h3FFF, 14'd0, 14'd1);
		repeat (SOAK_TICKS) send_tick(1'b0, 1'b1, 1'b0, '0);
		repeat (8) send_tick(1'b1, 1'b1, 1'b0, '0);

		wait_quiet();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && awaited_reports.size() == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule

// File: filelist.f
src/odkar_pkg.sv
src/open_drain_key_auto_repeater_unit.sv
tb/sv/testbench.sv
